### rtl/core/nlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared codes, field widths and the result word type for the permutation
// unit.
// ----------------------------------------------------------------------------
package nlp_pkg;

	// command codes carried on the input tuser
	localparam logic [1:0] CMD_WRITE    = 2'd0;
	localparam logic [1:0] CMD_IDENTITY = 2'd1;
	localparam logic [1:0] CMD_NEXT     = 2'd2;

	// fixed field widths of the stream words
	localparam int CMD_BITS  = 2;
	localparam int IDX_BITS  = 4;
	localparam int VAL_BITS  = 8;
	localparam int POS_BITS  = 4;
	localparam int ELEM_BITS = 8;

	// cap on the number of elements emitted per advance
	localparam int MAX_RESULTS = 16;

	// register map: register index is paddr[2]
	localparam logic REG_LENGTH = 1'b0;
	localparam logic [4:0] LENGTH_RESET = 5'd16;

	typedef struct packed {
		logic                 last;
		logic                 advanced;
		logic [ELEM_BITS-1:0] element;
		logic [POS_BITS-1:0]  position;
	} out_word_t;

endpackage

### rtl/core/next_lexicographic_permutation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_unit
// Holds a sequence of small values in a synchronous RAM and steps it to its
// next lexicographic (multiset) permutation on command.
//
// Usage:
//  - Input stream (s_axis_*): one word per command. tuser carries the command
//    (write entry, load identity order, advance), tdata the index and value
//    of a write. Write and identity emit nothing.
//  - Output stream (m_axis_*): an advance emits min(n, 16) words, one per
//    entry in order, with tlast on the final one and tuser set when a next
//    permutation existed (clear when the sequence was final and unchanged).
//  - APB port: register 0 (length) at byte address 0 sets the number n of
//    entries in use; 0 counts as 1, values above MAX_LEN saturate.
//  - Advance: a pivot scan and a successor scan of one RAM read a cycle
//    each, two swap writes, a paired read and two writes per reversed pair
//    (the single RAM write port sets this), then the words go out in order.
//  - The unit takes one command at a time; the next one is accepted as soon
//    as the last word sits in the output register, even if it is not taken.
//  - Reset restores identity order (entry i holds i) at once through per
//    entry valid bits, and sets length to 16.
//  - A stalled receiver holds the output register and the emit sequence;
//    nothing is dropped.
// ----------------------------------------------------------------------------
module next_lexicographic_permutation_unit #(
	parameter int MAX_LEN    = 16,
	parameter int VALUE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [3:0] index, [11:4] value, [15:12] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] command
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [3:0] position, [11:4] element, [15:12] zero
	output logic [0:0]  m_axis_tuser,   // [0] advanced
	output logic        m_axis_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import nlp_pkg::*;

	localparam int AW = $clog2(MAX_LEN);
	localparam int RES_LAST = ((MAX_LEN < MAX_RESULTS) ? MAX_LEN : MAX_RESULTS) - 1;

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PIV0 = 4'd1;  // first entry of the pivot scan arrives
	localparam logic [3:0] ST_PIV  = 4'd2;  // pivot scan, right to left
	localparam logic [3:0] ST_SUC  = 4'd3;  // successor scan, right to left
	localparam logic [3:0] ST_SW1  = 4'd4;  // write successor into pivot slot
	localparam logic [3:0] ST_SW2  = 4'd5;  // write pivot into successor slot
	localparam logic [3:0] ST_RRD  = 4'd6;  // read first suffix pair
	localparam logic [3:0] ST_RW1  = 4'd7;  // write low side of pair
	localparam logic [3:0] ST_RW2  = 4'd8;  // write high side, read next pair
	localparam logic [3:0] ST_EMIT = 4'd9;  // stream entries out

	logic [3:0] state_q, state_d;

	// configuration
	logic [4:0] length_q;
	logic       cfg_wr;

	// sequence RAM and its valid bits
	logic [VALUE_BITS-1:0] mem [MAX_LEN];
	logic [MAX_LEN-1:0]    vld_q;
	logic                  we, rea, reb;
	logic [AW-1:0]         wa, ra, rb;
	logic [VALUE_BITS-1:0] wd;
	logic [VALUE_BITS-1:0] rdma_s1, rdmb_s1;
	logic                  va_s1, vb_s1;
	logic [AW-1:0]         ra_s1, rb_s1;
	logic [VALUE_BITS-1:0] rda, rdb;

	// working registers
	logic [AW-1:0]         last_q, cntl_q, p_q, k_q, lo_q, hi_q;
	logic [VALUE_BITS-1:0] prev_q, pv_q, kv_q, tmp_q;
	logic                  adv_q;
	logic [AW-1:0]         last_n, cntl_n;

	// output register
	out_word_t out_q;
	logic      ovalid_q;

	logic in_acc, out_free, idx_ok, identity_cmd;
	logic [CMD_BITS-1:0] cmd;
	logic [IDX_BITS-1:0] idx;
	logic [VAL_BITS-1:0] val;

	assign cmd = s_axis_tuser;
	assign idx = s_axis_tdata[IDX_BITS-1:0];
	assign val = s_axis_tdata[IDX_BITS+VAL_BITS-1:IDX_BITS];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_free      = ~ovalid_q | m_axis_tready;
	assign idx_ok        = (32'(idx) < 32'(MAX_LEN));
	assign identity_cmd  = in_acc & (cmd == CMD_IDENTITY);

	// APB: always ready, single register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_LENGTH);
	assign prdata = (paddr[2] == REG_LENGTH) ? {27'd0, length_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= LENGTH_RESET;
		end else if (cfg_wr) begin
			length_q <= pwdata[4:0];
		end
	end

	// effective length minus one, and index of the final emitted entry
	always_comb begin
		if (length_q == 5'd0) begin
			last_n = '0;
		end else if (32'(length_q) > 32'(MAX_LEN)) begin
			last_n = AW'(MAX_LEN - 1);
		end else begin
			last_n = AW'(length_q - 5'd1);
		end
		if (32'(last_n) > 32'(RES_LAST)) begin
			cntl_n = AW'(RES_LAST);
		end else begin
			cntl_n = last_n;
		end
	end

	// RAM: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rea) begin
			rdma_s1 <= mem[ra];
			va_s1   <= vld_q[ra];
			ra_s1   <= ra;
		end
		if (reb) begin
			rdmb_s1 <= mem[rb];
			vb_s1   <= vld_q[rb];
			rb_s1   <= rb;
		end
	end

	// an entry never written since reset or identity reads as its own index
	assign rda = va_s1 ? rdma_s1 : VALUE_BITS'(ra_s1);
	assign rdb = vb_s1 ? rdmb_s1 : VALUE_BITS'(rb_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (identity_cmd) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[wa] <= 1'b1;
		end
	end

	// sequencer: RAM controls and next state
	always_comb begin
		state_d = state_q;
		we  = 1'b0;
		wa  = '0;
		wd  = '0;
		rea = 1'b0;
		ra  = '0;
		reb = 1'b0;
		rb  = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (cmd)
						CMD_WRITE: begin
							if (idx_ok) begin
								we = 1'b1;
								wa = AW'(idx);
								wd = VALUE_BITS'(val);
							end
						end
						CMD_NEXT: begin
							// a single entry goes straight to emit (read of entry 0)
							rea = 1'b1;
							ra  = last_n;
							state_d = (last_n == '0) ? ST_EMIT : ST_PIV0;
						end
						default: ;
					endcase
				end
			end
			ST_PIV0: begin
				rea = 1'b1;
				ra  = ra_s1 - AW'(1);
				state_d = ST_PIV;
			end
			ST_PIV: begin
				rea = 1'b1;
				if (rda < prev_q) begin
					ra = last_q;
					state_d = ST_SUC;
				end else if (ra_s1 == '0) begin
					ra = '0;
					state_d = ST_EMIT;
				end else begin
					ra = ra_s1 - AW'(1);
				end
			end
			ST_SUC: begin
				if (rda > pv_q) begin
					state_d = ST_SW1;
				end else begin
					rea = 1'b1;
					ra  = ra_s1 - AW'(1);
				end
			end
			ST_SW1: begin
				we = 1'b1;
				wa = p_q;
				wd = kv_q;
				state_d = ST_SW2;
			end
			ST_SW2: begin
				we = 1'b1;
				wa = k_q;
				wd = pv_q;
				if (lo_q < hi_q) begin
					state_d = ST_RRD;
				end else begin
					rea = 1'b1;
					ra  = '0;
					state_d = ST_EMIT;
				end
			end
			ST_RRD: begin
				rea = 1'b1;
				ra  = lo_q;
				reb = 1'b1;
				rb  = hi_q;
				state_d = ST_RW1;
			end
			ST_RW1: begin
				we = 1'b1;
				wa = lo_q;
				wd = rdb;
				state_d = ST_RW2;
			end
			ST_RW2: begin
				we = 1'b1;
				wa = hi_q;
				wd = tmp_q;
				rea = 1'b1;
				// the next pair never touches the entry written here
				if (({1'b0, lo_q} + (AW+1)'(2)) < {1'b0, hi_q}) begin
					ra  = lo_q + AW'(1);
					reb = 1'b1;
					rb  = hi_q - AW'(1);
					state_d = ST_RW1;
				end else begin
					ra = '0;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					if (ra_s1 == cntl_q) begin
						state_d = ST_IDLE;
					end else begin
						rea = 1'b1;
						ra  = ra_s1 + AW'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && out_free) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// working registers and output word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && cmd == CMD_NEXT) begin
					last_q <= last_n;
					cntl_q <= cntl_n;
					adv_q  <= 1'b0;
				end
			end
			ST_PIV0: begin
				prev_q <= rda;
			end
			ST_PIV: begin
				if (rda < prev_q) begin
					p_q   <= ra_s1;
					pv_q  <= rda;
					adv_q <= 1'b1;
				end else begin
					prev_q <= rda;
				end
			end
			ST_SUC: begin
				if (rda > pv_q) begin
					k_q  <= ra_s1;
					kv_q <= rda;
					lo_q <= p_q + AW'(1);
					hi_q <= last_q;
				end
			end
			ST_RW1: begin
				tmp_q <= rda;
			end
			ST_RW2: begin
				lo_q <= lo_q + AW'(1);
				hi_q <= hi_q - AW'(1);
			end
			ST_EMIT: begin
				if (out_free) begin
					out_q.position <= POS_BITS'(ra_s1);
					out_q.element  <= ELEM_BITS'(rda);
					out_q.advanced <= adv_q;
					out_q.last     <= (ra_s1 == cntl_q);
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {4'd0, out_q.element, out_q.position};
	assign m_axis_tuser  = out_q.advanced;
	assign m_axis_tlast  = out_q.last;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the permutation unit. Commands go in on the input
// stream, the length register is set over APB while the unit is idle, and
// every output word is checked against a behavioural copy of the sequence
// kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb;
	import nlp_pkg::*;

	// command code that the unit must ignore
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SEQ_DEPTH     = 16;
	// long enough for the longest advance to finish, with margin
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_LIMIT  = 10;

	// ------------------------------------------------------------------
	// Scoreboard: keeps its own copy of the sequence and the length
	// register, predicts the words of each advance and checks them in
	// order.
	// ------------------------------------------------------------------
	class perm_scoreboard;
		logic [ELEM_BITS-1:0] order [SEQ_DEPTH];
		logic [4:0]           length_reg;
		out_word_t            expected_words [$];
		int                   mismatches;

		function new();
			load_identity();
			length_reg = LENGTH_RESET;
			mismatches = 0;
		endfunction

		function void load_identity();
			for (int i = 0; i < SEQ_DEPTH; i++)
				order[i] = ELEM_BITS'(i);
		endfunction

		function void set_length(logic [4:0] len);
			length_reg = len;
		endfunction

		function int outstanding();
			return expected_words.size();
		endfunction

		function void note_mismatch(string what);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("[%0t] %s", $realtime, what);
		endfunction

		// Step the first n entries to their next permutation; return 0 and
		// leave them untouched when they are already in final order.
		function bit step_order(int n);
			int j;
			int k;
			int lo;
			int hi;
			logic [ELEM_BITS-1:0] t;
			if (n < 2)
				return 1'b0;
			j = n - 1;
			while (j > 0 && !(order[j-1] < order[j]))
				j--;
			if (j == 0)
				return 1'b0;
			j--;
			k = n - 1;
			while (order[j] >= order[k])
				k--;
			t = order[j];
			order[j] = order[k];
			order[k] = t;
			lo = j + 1;
			hi = n - 1;
			while (lo < hi) begin
				t = order[lo];
				order[lo] = order[hi];
				order[hi] = t;
				lo++;
				hi--;
			end
			return 1'b1;
		endfunction

		// Note one accepted command word and queue the words it causes.
		function void note_command(logic [1:0] cmd, logic [IDX_BITS-1:0] idx,
				logic [VAL_BITS-1:0] val);
			int n;
			int count;
			bit moved;
			out_word_t w;
			case (cmd)
			CMD_WRITE: begin
				order[idx] = val;
			end
			CMD_IDENTITY: begin
				load_identity();
			end
			CMD_NEXT: begin
				if (length_reg == 0)
					n = 1;
				else if (length_reg > SEQ_DEPTH)
					n = SEQ_DEPTH;
				else
					n = length_reg;
				moved = step_order(n);
				count = (n < MAX_RESULTS) ? n : MAX_RESULTS;
				for (int i = 0; i < count; i++) begin
					w.position = POS_BITS'(i);
					w.element  = order[i];
					w.advanced = moved;
					w.last     = (i == count - 1);
					expected_words.push_back(w);
				end
			end
			default: ;
			endcase
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (expected_words.size() == 0) begin
				note_mismatch($sformatf("unexpected word pos=%0d elem=%0d adv=%0d last=%0d",
					got.position, got.element, got.advanced, got.last));
				return;
			end
			want = expected_words.pop_front();
			if (got.position !== want.position || got.element !== want.element ||
					got.advanced !== want.advanced || got.last !== want.last)
				note_mismatch($sformatf(
					"word differs: exp pos=%0d elem=%0d adv=%0d last=%0d, got pos=%0d elem=%0d adv=%0d last=%0d",
					want.position, want.element, want.advanced, want.last,
					got.position, got.element, got.advanced, got.last));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [3:0] index, [11:4] value, [15:12] zero
	logic [1:0]  s_axis_tuser;   // [1:0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [3:0] position, [11:4] element, [15:12] zero
	logic [0:0]  m_axis_tuser;   // [0] advanced
	logic        m_axis_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	perm_scoreboard sb = new();
	int tx_idle_pct;
	int rx_idle_pct;
	int cycle_count = 0;

	next_lexicographic_permutation_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #6 clk = ~clk;

	// Give up on a hung run; the limit covers every word waiting out the
	// longest receiver stall several times over.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: drop tready at random in the share of cycles asked for.
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Check each output word as it is taken.
	always @(posedge clk) begin
		out_word_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.position = m_axis_tdata[3:0];
			got.element  = m_axis_tdata[11:4];
			got.advanced = m_axis_tuser[0];
			got.last     = m_axis_tlast;
			sb.check_word(got);
		end
	end

	// Offer one command word, idling first at random; hold it until taken.
	// Called and returns at a falling edge; tvalid stays high on return so
	// back-to-back words follow without a gap.
	task automatic send_word(logic [1:0] cmd, logic [3:0] idx, logic [7:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {4'h0, val, idx};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_command(cmd, idx, val);
		@(negedge clk);
	endtask

	// Drop tvalid and hold off until every predicted word has come back;
	// optionally let the unit settle before a register write.
	task automatic wait_results(bit settle);
		s_axis_tvalid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		@(negedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the length register over APB, then read it back.
	task automatic program_length(logic [4:0] len);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_LENGTH, 2'b00};
		pwdata  <= 32'(len);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_length(len);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[4:0] !== len)
			sb.note_mismatch($sformatf("length read back: exp %0d, got %0d", len, prdata[4:0]));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly advances and writes of small values, so that repeats and
	// final orders turn up; some identity loads and ignored codes as noise.
	task automatic send_random_item(int n_used);
		int r;
		logic [1:0] cmd;
		logic [3:0] idx;
		logic [7:0] val;
		r   = $urandom_range(99);
		idx = 4'($urandom_range(15));
		if ($urandom_range(99) < 70)
			idx = 4'($urandom_range(n_used - 1));
		val = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
		if (r < 50)
			cmd = CMD_NEXT;
		else if (r < 82)
			cmd = CMD_WRITE;
		else if (r < 92)
			cmd = CMD_IDENTITY;
		else
			cmd = CMD_UNUSED;
		send_word(cmd, idx, val);
	endtask

	initial begin
		int len_plan [12];
		int n_used;
		len_plan      = '{3, 4, 16, 2, 5, 17, 1, 4, 0, 6, 31, 3};
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_WRITE;
		m_axis_tready = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		tx_idle_pct   = 30;
		rx_idle_pct   = 75;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: advance straight from the reset order at full length,
		// extreme values at both ends, an ignored code, identity reload.
		send_word(CMD_NEXT, 4'h0, 8'h00);
		send_word(CMD_WRITE, 4'd0, 8'hFF);
		send_word(CMD_WRITE, 4'd15, 8'h00);
		send_word(CMD_NEXT, 4'hF, 8'hFF);
		send_word(CMD_UNUSED, 4'd5, 8'hAA);
		send_word(CMD_IDENTITY, 4'hA, 8'h55);
		send_word(CMD_NEXT, 4'h0, 8'h00);

		// Three entries in final order with a repeat: no advance, twice;
		// then break the order and advance once more.
		wait_results(1'b1);
		program_length(5'd3);
		send_word(CMD_WRITE, 4'd0, 8'd9);
		send_word(CMD_WRITE, 4'd1, 8'd5);
		send_word(CMD_WRITE, 4'd2, 8'd5);
		send_word(CMD_NEXT, 4'h0, 8'h00);
		send_word(CMD_NEXT, 4'h0, 8'h00);
		send_word(CMD_WRITE, 4'd2, 8'd9);
		send_word(CMD_NEXT, 4'h0, 8'h00);

		// A single entry, and a zero length that counts as one.
		wait_results(1'b1);
		program_length(5'd1);
		send_word(CMD_NEXT, 4'h0, 8'h00);
		wait_results(1'b1);
		program_length(5'd0);
		send_word(CMD_NEXT, 4'h0, 8'h00);

		// Largest register value saturates; a repeated tail value.
		wait_results(1'b1);
		program_length(5'd31);
		send_word(CMD_IDENTITY, 4'h0, 8'h00);
		send_word(CMD_WRITE, 4'd15, 8'd14);
		send_word(CMD_NEXT, 4'h0, 8'h00);

		// Random part in three idling phases, four lengths each, with a
		// full drain pause halfway through every block.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				tx_idle_pct = 30;
				rx_idle_pct = 75;
			end
			1: begin
				tx_idle_pct = 75;
				rx_idle_pct = 30;
			end
			default: begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				wait_results(1'b1);
				program_length(5'(len_plan[phase * 4 + blk]));
				n_used = len_plan[phase * 4 + blk];
				if (n_used == 0)
					n_used = 1;
				else if (n_used > SEQ_DEPTH)
					n_used = SEQ_DEPTH;
				for (int it = 0; it < 12; it++) begin
					if (it == 6)
						wait_results(1'b0);
					send_random_item(n_used);
				end
			end
		end

		// Drain, then watch a while longer for stray words.
		wait_results(1'b1);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
